[hdl/qsf_pkg.sv]
`timescale 1ns / 1ps

package qsf_pkg;

  localparam int COLOR_W   = 24;
  localparam int DIM_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [COLOR_W-1:0] FILL_COLOR_RESET    = 24'hFF0000;
  localparam logic [DIM_W-1:0]   SCREEN_WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0]   SCREEN_HEIGHT_RESET = 11'd360;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_COLOR    = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1,
    CFG_SCREEN_HEIGHT = 2'd2
  } cfg_idx_e;

  // request kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // step sign bits: set means the coordinate steps down
  localparam int SIGN_X = 0;
  localparam int SIGN_Y = 1;

endpackage

[hdl/qsf_in_if.sv]
`timescale 1ns / 1ps

interface qsf_in_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] vert0_x;
  logic signed [COORD_BITS-1:0] vert0_y;
  logic signed [COORD_BITS-1:0] vert1_x;
  logic signed [COORD_BITS-1:0] vert1_y;
  logic signed [COORD_BITS-1:0] vert2_x;
  logic signed [COORD_BITS-1:0] vert2_y;
  logic signed [COORD_BITS-1:0] vert3_x;
  logic signed [COORD_BITS-1:0] vert3_y;
  logic                         pairing;

  modport source (
    output valid, kind, vert0_x, vert0_y, vert1_x, vert1_y,
           vert2_x, vert2_y, vert3_x, vert3_y, pairing,
    input  ready
  );

  modport sink (
    input  valid, kind, vert0_x, vert0_y, vert1_x, vert1_y,
           vert2_x, vert2_y, vert3_x, vert3_y, pairing,
    output ready
  );
endinterface

[hdl/qsf_out_if.sv]
`timescale 1ns / 1ps

interface qsf_out_if #(
  parameter int COORD_BITS = 12
);
  import qsf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic                         on_screen;
  logic [COLOR_W-1:0]           pixel_color;
  logic                         last_of_quad;

  modport source (
    output valid, pixel_x, pixel_y, on_screen, pixel_color, last_of_quad,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, on_screen, pixel_color, last_of_quad,
    output ready
  );
endinterface

[hdl/qsf_line_init.sv]
`timescale 1ns / 1ps

// bresenham setup: absolute deltas, step signs and starting error
module qsf_line_init #(
  parameter int COORD_BITS = 12
) (
  input  logic signed [COORD_BITS-1:0] x0_i,
  input  logic signed [COORD_BITS-1:0] y0_i,
  input  logic signed [COORD_BITS-1:0] x1_i,
  input  logic signed [COORD_BITS-1:0] y1_i,
  output logic        [COORD_BITS-1:0] dx_o,
  output logic        [COORD_BITS-1:0] dy_o,
  output logic        [1:0]            signs_o,
  output logic signed [COORD_BITS+1:0] err_o
);
  import qsf_pkg::*;

  logic signed [COORD_BITS:0] diff_x;
  logic signed [COORD_BITS:0] diff_y;
  logic signed [COORD_BITS:0] abs_x;
  logic signed [COORD_BITS:0] abs_y;

  always_comb begin
    diff_x = $signed({x1_i[COORD_BITS-1], x1_i}) - $signed({x0_i[COORD_BITS-1], x0_i});
    diff_y = $signed({y1_i[COORD_BITS-1], y1_i}) - $signed({y0_i[COORD_BITS-1], y0_i});
    abs_x  = diff_x[COORD_BITS] ? -diff_x : diff_x;
    abs_y  = diff_y[COORD_BITS] ? -diff_y : diff_y;
    dx_o   = abs_x[COORD_BITS-1:0];
    dy_o   = abs_y[COORD_BITS-1:0];
    signs_o         = '0;
    signs_o[SIGN_X] = !(x0_i < x1_i);
    signs_o[SIGN_Y] = !(y0_i < y1_i);
    err_o  = $signed({2'b00, dx_o}) - $signed({2'b00, dy_o});
  end
endmodule

[hdl/qsf_line_step.sv]
`timescale 1ns / 1ps

// one bresenham step; passes the point through when disabled or degenerate
module qsf_bres_step #(
  parameter int COORD_BITS = 12
) (
  input  logic                         en_i,
  input  logic signed [COORD_BITS-1:0] pos_x_i,
  input  logic signed [COORD_BITS-1:0] pos_y_i,
  input  logic signed [COORD_BITS+1:0] err_i,
  input  logic        [COORD_BITS-1:0] dx_i,
  input  logic        [COORD_BITS-1:0] dy_i,
  input  logic        [1:0]            signs_i,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output logic signed [COORD_BITS+1:0] err_o
);
  import qsf_pkg::*;

  logic signed [COORD_BITS+2:0] e2;
  logic signed [COORD_BITS+2:0] dx_ext;
  logic signed [COORD_BITS+2:0] dy_ext;
  logic signed [COORD_BITS+2:0] err_sum;
  logic                         move;
  logic                         step_x;
  logic                         step_y;

  always_comb begin
    move    = en_i && !(dx_i == '0 && dy_i == '0);
    e2      = $signed({err_i, 1'b0});
    dx_ext  = $signed({3'b000, dx_i});
    dy_ext  = $signed({3'b000, dy_i});
    step_x  = move && (e2 > -dy_ext);
    step_y  = move && (e2 < dx_ext);
    err_sum = $signed({err_i[COORD_BITS+1], err_i})
              - (step_x ? dy_ext : '0) + (step_y ? dx_ext : '0);
    err_o   = err_sum[COORD_BITS+1:0];
    pos_x_o = pos_x_i;
    pos_y_o = pos_y_i;
    if (step_x) begin
      pos_x_o = signs_i[SIGN_X] ? pos_x_i - 1'b1 : pos_x_i + 1'b1;
    end
    if (step_y) begin
      pos_y_o = signs_i[SIGN_Y] ? pos_y_i - 1'b1 : pos_y_i + 1'b1;
    end
  end
endmodule

[hdl/quad_span_fill_rasterizer.sv]
`timescale 1ns / 1ps

// Quad span-fill rasterizer. A load request takes four vertices and the edge
// pairing and sets up two bresenham edges plus the first span; it produces no
// pixel. Each tick request while a quad is loaded produces exactly one pixel
// and moves the walk by one step, so the block takes one request per clock and
// gives one pixel per clock while out_o.ready is high; the limit is the single
// state update per cycle (span step, or edge step followed by span setup).
// Pixels sit in an output register, and a new request is taken whenever that
// register is empty or being drained. A tick with no quad loaded is taken and
// dropped, and a load replaces any quad in progress. Configuration writes take
// effect at once and belong in idle time only.
module quad_span_fill_rasterizer #(
  parameter int COORD_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [qsf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [qsf_pkg::COLOR_W-1:0]     cfg_data_i,
  qsf_in_if.sink                          in_i,
  qsf_out_if.source                       out_o
);
  import qsf_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int CMPW = ((CW > DIM_W) ? CW : DIM_W) + 1;

  // configuration
  logic [COLOR_W-1:0] fill_color_q;
  logic [DIM_W-1:0]   screen_width_q;
  logic [DIM_W-1:0]   screen_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_color_q    <= FILL_COLOR_RESET;
      screen_width_q  <= SCREEN_WIDTH_RESET;
      screen_height_q <= SCREEN_HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FILL_COLOR:    fill_color_q    <= cfg_data_i;
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data_i[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // walk state
  logic                 busy_q, busy_d;
  logic signed [CW-1:0] a_x_q, a_y_q, a_end_x_q, a_end_y_q;
  logic signed [CW+1:0] a_err_q;
  logic        [CW-1:0] a_dx_q, a_dy_q;
  logic        [1:0]    a_signs_q;
  logic signed [CW-1:0] b_x_q, b_y_q, b_end_x_q, b_end_y_q;
  logic signed [CW+1:0] b_err_q;
  logic        [CW-1:0] b_dx_q, b_dy_q;
  logic        [1:0]    b_signs_q;
  logic signed [CW-1:0] s_x_q, s_y_q;
  logic signed [CW+1:0] s_err_q;
  logic        [CW-1:0] s_dx_q, s_dy_q;
  logic        [1:0]    s_signs_q;

  // output register
  logic                 out_valid_q;
  logic signed [CW-1:0] pix_x_q, pix_y_q;
  logic                 on_screen_q, last_q;
  logic [COLOR_W-1:0]   pix_color_q;

  logic take, is_load, is_tick;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign take       = in_i.valid && in_i.ready;
  assign is_load    = take && (in_i.kind == KIND_LOAD);
  assign is_tick    = take && (in_i.kind == KIND_TICK) && busy_q;

  // edge endpoints from the pairing bit
  logic signed [CW-1:0] ld_a1_x, ld_a1_y, ld_b0_x, ld_b0_y;
  assign ld_a1_x = in_i.pairing ? in_i.vert1_x : in_i.vert2_x;
  assign ld_a1_y = in_i.pairing ? in_i.vert1_y : in_i.vert2_y;
  assign ld_b0_x = in_i.pairing ? in_i.vert2_x : in_i.vert1_x;
  assign ld_b0_y = in_i.pairing ? in_i.vert2_y : in_i.vert1_y;

  logic        [CW-1:0] la_dx, la_dy, lb_dx, lb_dy;
  logic        [1:0]    la_signs, lb_signs;
  logic signed [CW+1:0] la_err, lb_err;

  qsf_line_init #(.COORD_BITS(CW)) u_init_a (
    .x0_i(in_i.vert0_x), .y0_i(in_i.vert0_y), .x1_i(ld_a1_x), .y1_i(ld_a1_y),
    .dx_o(la_dx), .dy_o(la_dy), .signs_o(la_signs), .err_o(la_err)
  );

  qsf_line_init #(.COORD_BITS(CW)) u_init_b (
    .x0_i(ld_b0_x), .y0_i(ld_b0_y), .x1_i(in_i.vert3_x), .y1_i(in_i.vert3_y),
    .dx_o(lb_dx), .dy_o(lb_dy), .signs_o(lb_signs), .err_o(lb_err)
  );

  // tick decisions
  logic a_done, b_done, span_done, last;
  assign a_done    = (a_x_q == a_end_x_q) && (a_y_q == a_end_y_q);
  assign b_done    = (b_x_q == b_end_x_q) && (b_y_q == b_end_y_q);
  assign span_done = (s_x_q == b_x_q) && (s_y_q == b_y_q);
  assign last      = span_done && a_done && b_done;

  logic signed [CW-1:0] na_x, na_y, nb_x, nb_y, ns_x, ns_y;
  logic signed [CW+1:0] na_err, nb_err, ns_err;

  qsf_bres_step #(.COORD_BITS(CW)) u_step_a (
    .en_i(span_done && !a_done), .pos_x_i(a_x_q), .pos_y_i(a_y_q), .err_i(a_err_q),
    .dx_i(a_dx_q), .dy_i(a_dy_q), .signs_i(a_signs_q),
    .pos_x_o(na_x), .pos_y_o(na_y), .err_o(na_err)
  );

  qsf_bres_step #(.COORD_BITS(CW)) u_step_b (
    .en_i(span_done && !b_done), .pos_x_i(b_x_q), .pos_y_i(b_y_q), .err_i(b_err_q),
    .dx_i(b_dx_q), .dy_i(b_dy_q), .signs_i(b_signs_q),
    .pos_x_o(nb_x), .pos_y_o(nb_y), .err_o(nb_err)
  );

  qsf_bres_step #(.COORD_BITS(CW)) u_step_s (
    .en_i(!span_done), .pos_x_i(s_x_q), .pos_y_i(s_y_q), .err_i(s_err_q),
    .dx_i(s_dx_q), .dy_i(s_dy_q), .signs_i(s_signs_q),
    .pos_x_o(ns_x), .pos_y_o(ns_y), .err_o(ns_err)
  );

  // new span runs from edge A to edge B, either fresh from a load or after edge steps
  logic signed [CW-1:0] sp_x0, sp_y0, sp_x1, sp_y1;
  logic        [CW-1:0] sp_dx, sp_dy;
  logic        [1:0]    sp_signs;
  logic signed [CW+1:0] sp_err;

  assign sp_x0 = is_load ? in_i.vert0_x : na_x;
  assign sp_y0 = is_load ? in_i.vert0_y : na_y;
  assign sp_x1 = is_load ? ld_b0_x : nb_x;
  assign sp_y1 = is_load ? ld_b0_y : nb_y;

  qsf_line_init #(.COORD_BITS(CW)) u_init_s (
    .x0_i(sp_x0), .y0_i(sp_y0), .x1_i(sp_x1), .y1_i(sp_y1),
    .dx_o(sp_dx), .dy_o(sp_dy), .signs_o(sp_signs), .err_o(sp_err)
  );

  // screen test
  logic on_screen;
  always_comb begin
    on_screen = !s_x_q[CW-1] && !s_y_q[CW-1]
                && ({{(CMPW-CW){1'b0}}, s_x_q} < {{(CMPW-DIM_W){1'b0}}, screen_width_q})
                && ({{(CMPW-CW){1'b0}}, s_y_q} < {{(CMPW-DIM_W){1'b0}}, screen_height_q});
  end

  always_comb begin
    busy_d = busy_q;
    if (is_load) begin
      busy_d = 1'b1;
    end else if (is_tick && last) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_load) begin
      a_x_q     <= in_i.vert0_x;
      a_y_q     <= in_i.vert0_y;
      a_end_x_q <= ld_a1_x;
      a_end_y_q <= ld_a1_y;
      a_err_q   <= la_err;
      a_dx_q    <= la_dx;
      a_dy_q    <= la_dy;
      a_signs_q <= la_signs;
      b_x_q     <= ld_b0_x;
      b_y_q     <= ld_b0_y;
      b_end_x_q <= in_i.vert3_x;
      b_end_y_q <= in_i.vert3_y;
      b_err_q   <= lb_err;
      b_dx_q    <= lb_dx;
      b_dy_q    <= lb_dy;
      b_signs_q <= lb_signs;
      s_x_q     <= in_i.vert0_x;
      s_y_q     <= in_i.vert0_y;
      s_err_q   <= sp_err;
      s_dx_q    <= sp_dx;
      s_dy_q    <= sp_dy;
      s_signs_q <= sp_signs;
    end else if (is_tick && !last) begin
      if (span_done) begin
        a_x_q     <= na_x;
        a_y_q     <= na_y;
        a_err_q   <= na_err;
        b_x_q     <= nb_x;
        b_y_q     <= nb_y;
        b_err_q   <= nb_err;
        s_x_q     <= na_x;
        s_y_q     <= na_y;
        s_err_q   <= sp_err;
        s_dx_q    <= sp_dx;
        s_dy_q    <= sp_dy;
        s_signs_q <= sp_signs;
      end else begin
        s_x_q   <= ns_x;
        s_y_q   <= ns_y;
        s_err_q <= ns_err;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (is_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_tick) begin
      pix_x_q     <= s_x_q;
      pix_y_q     <= s_y_q;
      on_screen_q <= on_screen;
      pix_color_q <= fill_color_q;
      last_q      <= last;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pixel_x      = pix_x_q;
  assign out_o.pixel_y      = pix_y_q;
  assign out_o.on_screen    = on_screen_q;
  assign out_o.pixel_color  = pix_color_q;
  assign out_o.last_of_quad = last_q;

endmodule
